// ----- rtl/core/trsh_pkg.sv -----
`default_nettype none

package trsh_pkg;

    // sign codes of a trigger sample
    typedef enum logic [1:0] {
        SIGN_ZERO = 2'd0,
        SIGN_POS  = 2'd1,
        SIGN_NEG  = 2'd2
    } sign_t;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OUT_LOW  = 2'd0,
        CFG_HIGH_END = 2'd1,
        CFG_SEED     = 2'd2
    } cfg_idx_t;

    localparam logic [31:0] LCG_MUL    = 32'd435898247;
    localparam logic [31:0] LCG_ADD    = 32'd382842987;
    localparam logic [10:0] SEED_MUL   = 11'd1319;
    localparam logic [31:0] GEN_RESET  = 32'd98396081;
    localparam logic [31:0] LOW_RESET  = 32'hFFFF0000;
    localparam logic [31:0] HIGH_RESET = 32'h00010000;

endpackage

`default_nettype wire

// ----- rtl/core/triggered_random_sample_hold.sv -----
// Random sample-and-hold driven by a 32-bit linear congruential generator.
// Input channel (s_valid/s_ready): one signed trigger sample per transfer.
// A zero crossing of the trigger sign (to positive from zero or below, or to
// negative from zero or above) picks a new value low + (high - low) * u in
// Q16.16, u taken from the low 31 generator bits, and steps the generator.
// Every input transfer yields one output transfer (m_valid/m_ready)
// carrying the held value after that sample.
// Configuration port: cfg_wr_en/cfg_addr/cfg_wdata, index 0 lower end,
// 1 upper end, 2 seed (loads generator with seed * 1319). Write only while idle.
// Pipeline: an accepted sample passes the trigger stage, the range multiplier
// stage and the output add stage in turn, and m_valid is the valid flag of the
// output add stage.
// Throughput: one item per cycle while the receiver does not stall; the
// generator step is one 32-bit multiply and add in the trigger stage.
// Reset: registers return to their defaults, the held value to zero and the
// generator to 74599 * 1319; the pipeline empties.
// When the receiver stalls, the three stages fill up and s_ready drops only
// once all of them hold an item.
`default_nettype none

module triggered_random_sample_hold
    import trsh_pkg::*;
#(
    parameter int unsigned TRIGGER_WIDTH = 24
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [TRIGGER_WIDTH-1:0] s_trigger_sample,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [31:0]                   m_held_value,
    input  wire logic                     cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]     cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]    cfg_wdata
);

    logic [31:0] low_reg, high_reg;
    logic [32:0] range_reg;
    logic [31:0] gen_reg;
    sign_t       prev_sign_reg;

    logic        v1_reg, v2_reg, v3_reg;
    logic        ev1_reg, ev2_reg;
    logic [30:0] frac1_reg;
    logic [63:0] prod_reg;
    logic [31:0] hold_reg;

    logic        en2, en3, accept;
    sign_t       cur_sign;
    logic        event_hit;
    logic [31:0] gen_step;
    logic [31:0] seed_prod;
    logic [63:0] prod_full;
    logic [31:0] val_sum;
    logic        trunc_fix;

    assign en3    = ~v3_reg | m_ready;
    assign en2    = ~v2_reg | en3;
    assign s_ready = ~v1_reg | en2;
    assign accept = s_valid & s_ready;

    always_comb begin
        if (s_trigger_sample == '0) begin
            cur_sign = SIGN_ZERO;
        end else if (s_trigger_sample[TRIGGER_WIDTH-1]) begin
            cur_sign = SIGN_NEG;
        end else begin
            cur_sign = SIGN_POS;
        end
    end

    assign event_hit = ((cur_sign == SIGN_POS) && (prev_sign_reg != SIGN_POS)) ||
                       ((cur_sign == SIGN_NEG) && (prev_sign_reg != SIGN_NEG));

    assign gen_step  = gen_reg * LCG_MUL + LCG_ADD;
    assign seed_prod = cfg_wdata * {21'd0, SEED_MUL};

    // configuration and generator state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg       <= LOW_RESET;
            high_reg      <= HIGH_RESET;
            gen_reg       <= GEN_RESET;
            prev_sign_reg <= SIGN_ZERO;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_OUT_LOW:  low_reg  <= cfg_wdata;
                    CFG_HIGH_END: high_reg <= cfg_wdata;
                    CFG_SEED:     gen_reg  <= seed_prod;
                    default: ;
                endcase
            end
            if (accept) begin
                prev_sign_reg <= cur_sign;
                if (event_hit && !(cfg_wr_en && cfg_addr == CFG_SEED)) begin
                    gen_reg <= gen_step;
                end
            end
        end
    end

    // range is static between config writes
    always_ff @(posedge aclk) begin
        range_reg <= {high_reg[31], high_reg} - {low_reg[31], low_reg};
    end

    // stage 1: trigger decision and fraction capture
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (s_ready) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            ev1_reg   <= event_hit;
            frac1_reg <= gen_reg[30:0];
        end
    end

    // stage 2: range times fraction, exact in 64 bits
    assign prod_full = $signed(range_reg) * $signed({1'b0, frac1_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en2) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en2 && v1_reg) begin
            ev2_reg  <= ev1_reg;
            prod_reg <= prod_full;
        end
    end

    // stage 3: divide by 2^31 toward zero, add low end
    assign trunc_fix = prod_reg[63] & (|prod_reg[30:0]);
    assign val_sum   = low_reg + prod_reg[62:31] + {31'd0, trunc_fix};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg   <= 1'b0;
            hold_reg <= '0;
        end else if (en3) begin
            v3_reg <= v2_reg;
            if (v2_reg && ev2_reg) begin
                hold_reg <= val_sum;
            end
        end
    end

    assign m_valid      = v3_reg;
    assign m_held_value = hold_reg;

    a_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (v1_reg && v2_reg && v3_reg))
        else $error("input stalled with a free stage");

    a_hold_only_on_event: assert property (@(posedge aclk) disable iff (!aresetn)
        !(en3 && v2_reg && ev2_reg) |=> $stable(hold_reg))
        else $error("held value changed without a trigger event");

    a_gen_only_on_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (!(accept && event_hit) && !(cfg_wr_en && cfg_addr == CFG_SEED))
        |=> $stable(gen_reg))
        else $error("generator moved without event or seed write");

    a_out_from_stage2: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(v3_reg) |-> $past(v2_reg))
        else $error("output valid without a stage 2 item");

endmodule

`default_nettype wire
